// ===== src/cbpf_pkg.sv =====
package cbpf_pkg;

  // Frame geometry
  localparam int FRAME_WIDTH  = 128;
  localparam int FRAME_HEIGHT = 64;
  localparam int PAGE_ROWS    = 8;
  localparam int PAGES        = FRAME_HEIGHT / PAGE_ROWS;

  localparam int COL_W  = $clog2(FRAME_WIDTH);
  localparam int ROW_W  = $clog2(FRAME_HEIGHT);
  localparam int PAGE_W = $clog2(PAGES);
  localparam int LANE_W = $clog2(PAGE_ROWS);

  // One store word holds the eight pixel bytes of one page column
  localparam int PIX_W  = 8;
  localparam int WORD_W = PAGE_ROWS * PIX_W;
  localparam int DEPTH  = PAGES * FRAME_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);

  // Input field widths
  localparam int COORD_W = 16;
  localparam int SIZE_W  = 16;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_BLIT  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Clip result for the current blit beat
  typedef struct packed {
    logic                hit;
    logic [ADDR_W-1:0]   addr;
    logic [LANE_W-1:0]   lane;
    logic [SIZE_W-1:0]   col_next;
    logic [SIZE_W-1:0]   row_next;
  } clip_t;

  // Pack one page column: OR of each row byte shifted by its row, kept to a byte
  function automatic logic [PIX_W-1:0] pack_page(input logic [WORD_W-1:0] word);
    logic [PIX_W-1:0] acc;
    acc = '0;
    for (int j = 0; j < PAGE_ROWS; j++) begin
      acc = acc | PIX_W'(word[j*PIX_W +: PIX_W] << j);
    end
    return acc;
  endfunction

  // Replace one row byte within a page column word
  function automatic logic [WORD_W-1:0] merge_lane(input logic [WORD_W-1:0] word,
                                                   input logic [LANE_W-1:0] lane,
                                                   input logic [PIX_W-1:0]  pix);
    logic [WORD_W-1:0] res;
    res = word;
    for (int j = 0; j < PAGE_ROWS; j++) begin
      if (lane == LANE_W'(j)) begin
        res[j*PIX_W +: PIX_W] = pix;
      end
    end
    return res;
  endfunction

endpackage

// ===== src/cbpf_ram.sv =====
module cbpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/cbpf_clip.sv =====
module cbpf_clip
  import cbpf_pkg::*;
(
  input  logic signed [COORD_W-1:0] dest_x_i,
  input  logic signed [COORD_W-1:0] dest_y_i,
  input  logic        [SIZE_W-1:0]  bitmap_width_i,
  input  logic        [SIZE_W-1:0]  bitmap_height_i,
  input  logic        [SIZE_W-1:0]  col_cnt_i,
  input  logic        [SIZE_W-1:0]  row_cnt_i,
  output clip_t                     clip_o
);

  logic signed [COORD_W+1:0] px;
  logic signed [COORD_W+1:0] py;
  logic                      in_bitmap;
  logic                      in_frame;
  logic        [SIZE_W:0]    col_inc;
  logic        [SIZE_W:0]    row_inc;

  // Frame point for the current bitmap position
  assign px = $signed({{2{dest_x_i[COORD_W-1]}}, dest_x_i}) + $signed({2'b00, col_cnt_i});
  assign py = $signed({{2{dest_y_i[COORD_W-1]}}, dest_y_i}) + $signed({2'b00, row_cnt_i});

  assign in_bitmap = (col_cnt_i < bitmap_width_i) && (row_cnt_i < bitmap_height_i);
  assign in_frame  = (px >= 0) && (px < (COORD_W+2)'(FRAME_WIDTH)) &&
                     (py >= 0) && (py < (COORD_W+2)'(FRAME_HEIGHT));

  // Advance column, then row, wrapping at the bitmap size
  assign col_inc = {1'b0, col_cnt_i} + 1'b1;
  assign row_inc = {1'b0, row_cnt_i} + 1'b1;

  always_comb begin
    clip_o.hit      = in_bitmap && in_frame;
    clip_o.addr     = {py[ROW_W-1:LANE_W], px[COL_W-1:0]};
    clip_o.lane     = py[LANE_W-1:0];
    clip_o.col_next = col_inc[SIZE_W-1:0];
    clip_o.row_next = row_cnt_i;
    if (col_inc >= {1'b0, bitmap_width_i}) begin
      clip_o.col_next = '0;
      clip_o.row_next = (row_inc >= {1'b0, bitmap_height_i}) ? '0 : row_inc[SIZE_W-1:0];
    end
  end

endmodule

// ===== src/clipped_blit_page_framebuffer_unit.sv =====
// Page-organised framebuffer with clipped bitmap blit.
// Input channel (in_valid_i / in_ready_o) carries one action per beat:
//   clear  - zero the whole frame; walks all page columns, one per cycle,
//            and takes no beat until all PAGES*FRAME_WIDTH (1024) are done.
//   blit   - write one bitmap pixel at the current bitmap position if it lands
//            inside the frame; when it lands, read, merge and write back
//            one page column word (states IDLE, WR); when clipped, no access.
//   read   - return the packed byte of one page column; the memory word is
//            read on the accepting edge, and in state RD the packed byte is
//            loaded into the result register once that register is free.
// The store is one memory word per page column (eight pixel bytes), so a read
// costs one memory access and a landing blit one read-modify-write on the
// single port, which sets the pace. Items are handled one at a time.
// Output channel (out_valid_o / out_ready_i) has a result register: a new item
// is taken while a result waits; a second read completes only once the
// receiver has taken the first result.
// Reset clears the bitmap counters and runs the same clearing pass over the
// store before the first beat is accepted.
module clipped_blit_page_framebuffer_unit
  import cbpf_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                action_i,
  input  logic signed [COORD_W-1:0] dest_x_i,
  input  logic signed [COORD_W-1:0] dest_y_i,
  input  logic [SIZE_W-1:0]         bitmap_width_i,
  input  logic [SIZE_W-1:0]         bitmap_height_i,
  input  logic [PIX_W-1:0]          pixel_value_i,
  input  logic [2:0]                page_select_i,
  input  logic [6:0]                column_select_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [PIX_W-1:0]          page_byte_o,
  output logic [2:0]                page_echo_o,
  output logic [6:0]                column_echo_o
);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_WR   = 2'd2;
  localparam logic [1:0] ST_RD   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic [SIZE_W-1:0] col_cnt_q, col_cnt_d;
  logic [SIZE_W-1:0] row_cnt_q, row_cnt_d;
  logic [ADDR_W-1:0] wr_addr_q, wr_addr_d;
  logic [LANE_W-1:0] wr_lane_q, wr_lane_d;
  logic [PIX_W-1:0]  wr_pix_q, wr_pix_d;
  logic [2:0]        rd_page_q, rd_page_d;
  logic [6:0]        rd_col_q, rd_col_d;
  logic              out_valid_q, out_valid_d;
  logic [PIX_W-1:0]  page_byte_q, page_byte_d;
  logic [2:0]        page_echo_q, page_echo_d;
  logic [6:0]        column_echo_q, column_echo_d;

  logic              in_beat;
  action_e           act;
  clip_t             clip;
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  assign act     = action_e'(action_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_beat = in_valid_i && in_ready_o;

  cbpf_clip u_clip (
    .dest_x_i        (dest_x_i),
    .dest_y_i        (dest_y_i),
    .bitmap_width_i  (bitmap_width_i),
    .bitmap_height_i (bitmap_height_i),
    .col_cnt_i       (col_cnt_q),
    .row_cnt_i       (row_cnt_q),
    .clip_o          (clip)
  );

  cbpf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Sequence clear sweep, blit read-modify-write and page reads
  always_comb begin
    state_d       = state_q;
    clr_addr_d    = clr_addr_q;
    col_cnt_d     = col_cnt_q;
    row_cnt_d     = row_cnt_q;
    wr_addr_d     = wr_addr_q;
    wr_lane_d     = wr_lane_q;
    wr_pix_d      = wr_pix_q;
    rd_page_d     = rd_page_q;
    rd_col_d      = rd_col_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    page_byte_d   = page_byte_q;
    page_echo_d   = page_echo_q;
    column_echo_d = column_echo_q;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_addr      = clr_addr_q;
    ram_wdata     = '0;

    unique case (state_q)
      ST_CLR: begin
        ram_we     = 1'b1;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_beat) begin
          unique case (act)
            ACT_CLEAR: begin
              clr_addr_d = '0;
              state_d    = ST_CLR;
            end
            ACT_BLIT: begin
              col_cnt_d = clip.col_next;
              row_cnt_d = clip.row_next;
              wr_addr_d = clip.addr;
              wr_lane_d = clip.lane;
              wr_pix_d  = pixel_value_i;
              if (clip.hit) begin
                ram_re   = 1'b1;
                ram_addr = clip.addr;
                state_d  = ST_WR;
              end
            end
            ACT_READ: begin
              ram_re    = 1'b1;
              ram_addr  = {page_select_i[PAGE_W-1:0], column_select_i[COL_W-1:0]};
              rd_page_d = page_select_i;
              rd_col_d  = column_select_i;
              state_d   = ST_RD;
            end
            ACT_NONE: begin
              state_d = ST_IDLE;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_WR: begin
        ram_we    = 1'b1;
        ram_addr  = wr_addr_q;
        ram_wdata = merge_lane(ram_rdata, wr_lane_q, wr_pix_q);
        state_d   = ST_IDLE;
      end
      ST_RD: begin
        // Hold the read word until the result register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          page_byte_d   = pack_page(ram_rdata);
          page_echo_d   = rd_page_q;
          column_echo_d = rd_col_q;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_addr_q  <= '0;
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      col_cnt_q   <= col_cnt_d;
      row_cnt_q   <= row_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    wr_addr_q     <= wr_addr_d;
    wr_lane_q     <= wr_lane_d;
    wr_pix_q      <= wr_pix_d;
    rd_page_q     <= rd_page_d;
    rd_col_q      <= rd_col_d;
    page_byte_q   <= page_byte_d;
    page_echo_q   <= page_echo_d;
    column_echo_q <= column_echo_d;
  end

  assign out_valid_o   = out_valid_q;
  assign page_byte_o   = page_byte_q;
  assign page_echo_o   = page_echo_q;
  assign column_echo_o = column_echo_q;

  // The single memory port never reads and writes in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_we && ram_re))
    else $error("memory read and write collide");

  // An accepted read beat moves to the result stage next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (action_i == ACT_READ) |=> state_q == ST_RD)
    else $error("read beat did not reach result stage");

  // A write-back always follows the read of the same blit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WR |-> $past(state_q) == ST_IDLE && $past(ram_re))
    else $error("write-back without preceding read");

  // A result is loaded only from the result stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_RD)
    else $error("result appeared outside the read path");

endmodule
